FILE: hdl/pidc_pkg.sv
// shared types, widths and register codes of the pid controller step block
package pidc_pkg;

  // widths of the fixed fields
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ValW   = 16;
  localparam int unsigned GainW  = 24;
  localparam int unsigned CfgW   = 24;
  localparam int unsigned IntegW = 34;
  localparam int unsigned FracW  = 16;
  // widest intermediate sum: two 42 bit products plus a 34 bit integrator
  localparam int unsigned AccW   = 45;

  typedef logic        [TimeW-1:0]  time_t;
  typedef logic signed [ValW-1:0]   val_t;
  typedef logic        [GainW-1:0]  gain_t;
  typedef logic        [CfgW-1:0]   cfg_data_t;
  typedef logic signed [IntegW-1:0] integ_t;
  typedef logic signed [AccW-1:0]   acc_t;

  // register index codes
  typedef enum logic [2:0] {
    CFG_KP_GAIN      = 3'd0,
    CFG_KI_GAIN      = 3'd1,
    CFG_KD_GAIN      = 3'd2,
    CFG_OUT_MIN      = 3'd3,
    CFG_OUT_MAX      = 3'd4,
    CFG_P_ON_ERROR   = 3'd5,
    CFG_REVERSE      = 3'd6,
    CFG_SAMPLE_MS    = 3'd7
  } cfg_idx_t;

  // reset values of the registers
  localparam gain_t          KpReset     = '0;
  localparam gain_t          KiReset     = '0;
  localparam gain_t          KdReset     = '0;
  localparam val_t           OutMinReset = 16'sd0;
  localparam val_t           OutMaxReset = 16'sd100;
  localparam logic           PonEReset   = 1'b1;
  localparam logic           RevReset    = 1'b0;
  localparam logic [ValW-1:0] SampleReset = 16'd100;

  // half an lsb of the output in q.16, for round half up
  localparam acc_t QHalf = acc_t'(32768);

  // integer limit scaled to q.16 and widened
  function automatic acc_t to_q(input val_t v);
    logic signed [ValW+FracW-1:0] q;
    begin
      q = $signed({v, {FracW{1'b0}}});
      return acc_t'(q);
    end
  endfunction

  // upper limit tested first, then the lower one
  function automatic acc_t clamp_q(input acc_t v, input val_t lo, input val_t hi);
    acc_t hi_q;
    acc_t lo_q;
    begin
      hi_q = to_q(hi);
      lo_q = to_q(lo);
      if (v > hi_q)      return hi_q;
      else if (v < lo_q) return lo_q;
      else               return v;
    end
  endfunction

endpackage

FILE: hdl/pid_controller_step_top.sv
// pid controller step with anti-windup: input register, one pass of logic, result register
// an accepted input beat passes the input register and then the result register
// throughput: one beat per cycle while out_ready does not hold the result register; the
//   state loop runs through the four gain products, the integrator clamp and the output clamp
// reset: rst_n synchronous active low; clears both pipeline stages, the controller
//   state (manual mode, first auto item computes) and loads the register defaults
module pid_controller_step_top (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  pidc_pkg::cfg_data_t       cfg_wdata,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pidc_pkg::time_t           in_time_ms,
  input  pidc_pkg::val_t            in_measurement,
  input  pidc_pkg::val_t            in_setpoint,
  input  logic                      in_auto_mode,
  input  pidc_pkg::val_t            in_manual_output,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_computed,
  output pidc_pkg::val_t            out_control_output
);
  import pidc_pkg::*;

  // configuration registers
  gain_t            kp_r, ki_r, kd_r;
  val_t             out_min_r, out_max_r;
  logic             p_on_error_r, reverse_r;
  logic [ValW-1:0]  sample_ms_r;

  // input stage
  logic             s_valid_r;
  time_t            s_time_r;
  val_t             s_meas_r, s_sp_r, s_man_r;
  logic             s_auto_r;

  // controller state
  integ_t           integ_r;
  val_t             prev_meas_r;
  time_t            last_time_r;
  val_t             held_r;
  logic             was_auto_r;
  logic             time_valid_r;

  // result stage
  logic             out_valid_r;
  logic             out_computed_r;
  val_t             out_value_r;

  // handshake
  logic             advance;
  logic             process;

  // datapath
  acc_t             integ_base;
  val_t             prev_base;
  logic             tv_base;
  time_t            elapsed;
  logic             do_comp;
  logic signed [GainW:0] kp_s, ki_s, kd_s;
  logic signed [ValW:0]  err, dm;
  logic signed [GainW+ValW+1:0] kp_err, ki_err, kp_dm, kd_dm;
  acc_t             i_sum, integ_new, o_sum, o_clamped, o_round;
  val_t             held_nxt;
  integ_t           integ_nxt;
  val_t             prev_meas_nxt;
  time_t            last_time_nxt;
  logic             was_auto_nxt, time_valid_nxt;

  // the result register frees up when empty or taken; the input stage follows
  assign advance  = !out_valid_r || out_ready;
  assign process  = s_valid_r && advance;
  assign in_ready = !s_valid_r || advance;

  // state as seen by this beat, with the manual to auto handover folded in
  always_comb begin
    tv_base    = was_auto_r && time_valid_r;
    integ_base = was_auto_r ? acc_t'(integ_r) : clamp_q(to_q(held_r), out_min_r, out_max_r);
    prev_base  = was_auto_r ? prev_meas_r : s_meas_r;
    elapsed    = s_time_r - last_time_r;
    do_comp    = s_auto_r && (!tv_base || (elapsed >= TimeW'(sample_ms_r)));
  end

  // signed gains, reverse action negates all three
  always_comb begin
    kp_s = reverse_r ? -$signed({1'b0, kp_r}) : $signed({1'b0, kp_r});
    ki_s = reverse_r ? -$signed({1'b0, ki_r}) : $signed({1'b0, ki_r});
    kd_s = reverse_r ? -$signed({1'b0, kd_r}) : $signed({1'b0, kd_r});
    err  = (ValW+1)'(s_sp_r) - (ValW+1)'(s_meas_r);
    dm   = (ValW+1)'(s_meas_r) - (ValW+1)'(prev_base);
  end

  // four products in parallel
  assign kp_err = kp_s * err;
  assign ki_err = ki_s * err;
  assign kp_dm  = kp_s * dm;
  assign kd_dm  = kd_s * dm;

  // integrator update and clamp, then output sum, clamp and round half up
  always_comb begin
    i_sum     = integ_base + acc_t'(ki_err) - (p_on_error_r ? '0 : acc_t'(kp_dm));
    integ_new = clamp_q(i_sum, out_min_r, out_max_r);
    o_sum     = (p_on_error_r ? acc_t'(kp_err) : '0) + integ_new - acc_t'(kd_dm);
    o_clamped = clamp_q(o_sum, out_min_r, out_max_r);
    o_round   = o_clamped + QHalf;
  end

  // next controller state
  always_comb begin
    integ_nxt      = integ_r;
    prev_meas_nxt  = prev_meas_r;
    last_time_nxt  = last_time_r;
    held_nxt       = held_r;
    was_auto_nxt   = was_auto_r;
    time_valid_nxt = time_valid_r;
    if (!s_auto_r) begin
      was_auto_nxt = 1'b0;
      held_nxt     = s_man_r;
    end else begin
      was_auto_nxt = 1'b1;
      if (!was_auto_r) begin
        integ_nxt      = IntegW'(integ_base);
        prev_meas_nxt  = s_meas_r;
        time_valid_nxt = 1'b0;
      end
      if (do_comp) begin
        integ_nxt      = IntegW'(integ_new);
        prev_meas_nxt  = s_meas_r;
        last_time_nxt  = s_time_r;
        held_nxt       = o_round[FracW +: ValW];
        time_valid_nxt = 1'b1;
      end
    end
  end

  // all registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r         <= KpReset;
      ki_r         <= KiReset;
      kd_r         <= KdReset;
      out_min_r    <= OutMinReset;
      out_max_r    <= OutMaxReset;
      p_on_error_r <= PonEReset;
      reverse_r    <= RevReset;
      sample_ms_r  <= SampleReset;
      s_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      integ_r      <= '0;
      prev_meas_r  <= '0;
      last_time_r  <= '0;
      held_r       <= '0;
      was_auto_r   <= 1'b0;
      time_valid_r <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_KP_GAIN:    kp_r         <= cfg_wdata[GainW-1:0];
          CFG_KI_GAIN:    ki_r         <= cfg_wdata[GainW-1:0];
          CFG_KD_GAIN:    kd_r         <= cfg_wdata[GainW-1:0];
          CFG_OUT_MIN:    out_min_r    <= $signed(cfg_wdata[ValW-1:0]);
          CFG_OUT_MAX:    out_max_r    <= $signed(cfg_wdata[ValW-1:0]);
          CFG_P_ON_ERROR: p_on_error_r <= cfg_wdata[0];
          CFG_REVERSE:    reverse_r    <= cfg_wdata[0];
          CFG_SAMPLE_MS:  sample_ms_r  <= cfg_wdata[ValW-1:0];
          default:        ;
        endcase
      end

      // input stage occupancy
      if (in_valid && in_ready) begin
        s_valid_r <= 1'b1;
      end else if (advance) begin
        s_valid_r <= 1'b0;
      end

      // result stage occupancy
      if (advance) begin
        out_valid_r <= s_valid_r;
      end

      // state update once per processed beat
      if (process) begin
        integ_r      <= integ_nxt;
        prev_meas_r  <= prev_meas_nxt;
        last_time_r  <= last_time_nxt;
        held_r       <= held_nxt;
        was_auto_r   <= was_auto_nxt;
        time_valid_r <= time_valid_nxt;
      end
    end

    // payload, no reset
    if (in_valid && in_ready) begin
      s_time_r <= in_time_ms;
      s_meas_r <= in_measurement;
      s_sp_r   <= in_setpoint;
      s_auto_r <= in_auto_mode;
      s_man_r  <= in_manual_output;
    end
    if (process) begin
      out_computed_r <= do_comp;
      out_value_r    <= held_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_computed       = out_computed_r;
  assign out_control_output = out_value_r;

endmodule
